>>> rtl/knapsack_01_solver_top_assert.svh
// Assertion macros for the knapsack solver.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef KNAPSACK_01_SOLVER_TOP_ASSERT_SVH
`define KNAPSACK_01_SOLVER_TOP_ASSERT_SVH

// Same-cycle implication
`define KS01_CHECK(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// Next-cycle implication
`define KS01_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/ks01_pkg.sv
// Shared types and fixed field widths for the knapsack solver.
// No dependencies.
package ks01_pkg;

    localparam int PROFIT_W = 16;
    localparam int WEIGHT_W = 8;
    localparam int SUM_W    = 22;
    localparam int NUM_W    = 7;
    localparam int CFG_W    = 8;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Register byte addresses
    localparam logic [2:0] ADDR_CAPACITY = 3'd0;

    // One take-bit write from the row engine
    typedef struct packed {
        logic valid;
        logic take;
    } take_wr_t;

endpackage

>>> rtl/ks01_row_engine.sv
// Best-profit row memory with its update, clear and total-read sequencer.
// Depends on ks01_pkg.
module ks01_row_engine
    import ks01_pkg::*;
#(
    parameter int MAX_CAPACITY = 255,
    localparam int CW = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY + 1) : 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start_update,
    input  logic [PROFIT_W-1:0] upd_profit,
    input  logic [WEIGHT_W-1:0] upd_weight,
    input  logic                start_clear,
    input  logic                start_total,
    input  logic [CW-1:0]       total_col,
    output logic                busy,
    output logic                total_valid,
    output logic [SUM_W-1:0]    total,
    output take_wr_t            take_wr,
    output logic [CW-1:0]       take_col
);

    localparam int XW = (CW > WEIGHT_W) ? CW : WEIGHT_W;

    typedef enum logic [1:0] {R_IDLE, R_UPD, R_CLR} rstate_t;

    logic [SUM_W-1:0] row_mem [0:MAX_CAPACITY];

    rstate_t             state_reg;
    logic [CW-1:0]       col_reg;
    logic [PROFIT_W-1:0] profit_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    logic                s1_vld_reg;
    logic [CW-1:0]       s1_col_reg;
    logic                s1_fit_reg;
    logic                tot_pend_reg;

    logic [SUM_W-1:0] rd_a_q;
    logic [SUM_W-1:0] rd_b_q;
    logic [CW-1:0]    rd_a_addr;
    logic [CW-1:0]    rd_b_addr;
    logic [XW-1:0]    colx;
    logic [XW-1:0]    wx;
    logic [XW-1:0]    diff;
    logic             fit;
    logic [SUM_W:0]   cand_full;
    logic [SUM_W-1:0] cand;
    logic             take;
    logic             we;
    logic [CW-1:0]    wr_addr;
    logic [SUM_W-1:0] wr_data;

    // Read addresses: current column (the total column while idle) and the column one item-weight below
    always_comb
    begin
        colx = XW'(col_reg);
        wx   = XW'(weight_reg);
        fit  = (wx <= colx);
        diff = colx - wx;
        rd_a_addr = (state_reg == R_IDLE) ? total_col : col_reg;
        rd_b_addr = fit ? diff[CW-1:0] : '0;
    end

    // Candidate profit with saturation, strict-improvement take
    always_comb
    begin
        cand_full = {1'b0, rd_b_q} + (SUM_W + 1)'(profit_reg);
        cand      = cand_full[SUM_W] ? SUM_MAX : cand_full[SUM_W-1:0];
        take      = s1_fit_reg && (cand > rd_a_q);
        we        = (state_reg == R_CLR) || (s1_vld_reg && take);
        wr_addr   = (state_reg == R_CLR) ? col_reg : s1_col_reg;
        wr_data   = (state_reg == R_CLR) ? '0 : cand;
    end

    // Row memory: one write, two registered reads. The sweep runs top down,
    // so later reads only touch columns below the one being written.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            row_mem[wr_addr] <= wr_data;
        end
        rd_a_q <= row_mem[rd_a_addr];
        rd_b_q <= row_mem[rd_b_addr];
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= R_CLR;
            col_reg      <= '0;
            profit_reg   <= '0;
            weight_reg   <= '0;
            s1_vld_reg   <= 1'b0;
            s1_col_reg   <= '0;
            s1_fit_reg   <= 1'b0;
            tot_pend_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg   <= 1'b0;
            tot_pend_reg <= (state_reg == R_IDLE) && start_total;
            unique case (state_reg)
                R_IDLE:
                begin
                    if (start_update)
                    begin
                        profit_reg <= upd_profit;
                        weight_reg <= upd_weight;
                        col_reg    <= CW'(MAX_CAPACITY);
                        state_reg  <= R_UPD;
                    end
                    else if (start_clear)
                    begin
                        col_reg   <= '0;
                        state_reg <= R_CLR;
                    end
                end
                R_UPD:
                begin
                    s1_vld_reg <= 1'b1;
                    s1_col_reg <= col_reg;
                    s1_fit_reg <= fit;
                    if (col_reg == CW'(1))
                    begin
                        state_reg <= R_IDLE;
                    end
                    else
                    begin
                        col_reg <= col_reg - 1'b1;
                    end
                end
                R_CLR:
                begin
                    if (col_reg == CW'(MAX_CAPACITY))
                    begin
                        state_reg <= R_IDLE;
                    end
                    else
                    begin
                        col_reg <= col_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= R_IDLE;
                end
            endcase
        end
    end

    assign busy          = (state_reg != R_IDLE) || s1_vld_reg;
    assign total_valid   = tot_pend_reg;
    assign total         = rd_a_q;
    assign take_wr.valid = s1_vld_reg;
    assign take_wr.take  = take;
    assign take_col      = s1_col_reg;

endmodule

>>> rtl/ks01_trace_out.sv
// Item store, take-bit memory, traceback and result output stage.
// Depends on ks01_pkg.
module ks01_trace_out
    import ks01_pkg::*;
#(
    parameter int MAX_ITEMS    = 64,
    parameter int MAX_CAPACITY = 255,
    localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1,
    localparam int NW = IW + 1,
    localparam int CW = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY + 1) : 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_wr,
    input  logic [IW-1:0]       item_idx,
    input  logic [PROFIT_W-1:0] wr_profit,
    input  logic [WEIGHT_W-1:0] wr_weight,
    input  take_wr_t            take_wr,
    input  logic [IW-1:0]       take_idx,
    input  logic [CW-1:0]       take_col,
    input  logic                start,
    input  logic [NW-1:0]       set_count,
    input  logic [CW-1:0]       cap,
    input  logic [SUM_W-1:0]    total_in,
    input  logic                dropped_in,
    output logic                busy,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [NUM_W-1:0]    item_number,
    output logic                selected,
    output logic [WEIGHT_W-1:0] out_weight,
    output logic [PROFIT_W-1:0] out_profit,
    output logic [SUM_W-1:0]    total_profit,
    output logic                dropped_items,
    output logic                last_result
);

    localparam int XW = (CW > WEIGHT_W) ? CW : WEIGHT_W;
    localparam int TD = MAX_ITEMS * (2 ** CW);

    typedef enum logic [2:0] {T_IDLE, T_RD, T_EVAL, O_RD, O_LOAD, O_WAIT} tstate_t;

    logic [PROFIT_W-1:0] prof_mem [0:MAX_ITEMS-1];
    logic [WEIGHT_W-1:0] wgt_mem  [0:MAX_ITEMS-1];
    logic                sel_mem  [0:MAX_ITEMS-1];
    logic                take_mem [0:TD-1];

    tstate_t          state_reg;
    logic [NW-1:0]    i_reg;
    logic [CW-1:0]    j_reg;
    logic [NW-1:0]    k_reg;
    logic [NW-1:0]    n_reg;
    logic [SUM_W-1:0] total_reg;
    logic             dropped_reg;
    logic             out_valid_reg;
    logic [NUM_W-1:0] number_reg;
    logic             selected_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    logic [PROFIT_W-1:0] profit_reg;
    logic             last_reg;

    logic [PROFIT_W-1:0] prof_q;
    logic [WEIGHT_W-1:0] wgt_q;
    logic                sel_q;
    logic                take_q;

    logic [NW-1:0] i_dec;
    logic [NW-1:0] k_inc;
    logic [IW-1:0] rd_idx;
    logic          tracing;
    logic          take_now;
    logic [XW-1:0] jx;
    logic [XW-1:0] wx;
    logic [XW-1:0] jdiff;
    logic [CW-1:0] j_next;

    // Address selection and traceback step
    always_comb
    begin
        i_dec    = i_reg - 1'b1;
        k_inc    = k_reg + 1'b1;
        tracing  = (state_reg == T_RD) || (state_reg == T_EVAL);
        rd_idx   = tracing ? i_dec[IW-1:0] : k_reg[IW-1:0];
        take_now = (j_reg != '0) && take_q;
        jx       = XW'(j_reg);
        wx       = XW'(wgt_q);
        jdiff    = jx - wx;
        if (!take_now)
        begin
            j_next = j_reg;
        end
        else if (jx >= wx)
        begin
            j_next = jdiff[CW-1:0];
        end
        else
        begin
            j_next = '0;
        end
    end

    // Item, take and selection memories, registered reads
    always_ff @(posedge clk)
    begin
        if (item_wr)
        begin
            prof_mem[item_idx] <= wr_profit;
            wgt_mem[item_idx]  <= wr_weight;
        end
        if (take_wr.valid)
        begin
            take_mem[{take_idx, take_col}] <= take_wr.take;
        end
        if (state_reg == T_EVAL)
        begin
            sel_mem[rd_idx] <= take_now;
        end
        prof_q <= prof_mem[rd_idx];
        wgt_q  <= wgt_mem[rd_idx];
        sel_q  <= sel_mem[rd_idx];
        take_q <= take_mem[{rd_idx, j_reg}];
    end

    // Traceback and output sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            n_reg         <= '0;
            total_reg     <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            number_reg    <= '0;
            selected_reg  <= 1'b0;
            weight_reg    <= '0;
            profit_reg    <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                T_IDLE:
                begin
                    if (start)
                    begin
                        i_reg       <= set_count;
                        n_reg       <= set_count;
                        j_reg       <= cap;
                        total_reg   <= total_in;
                        dropped_reg <= dropped_in;
                        state_reg   <= T_RD;
                    end
                end
                T_RD:
                begin
                    state_reg <= T_EVAL;
                end
                T_EVAL:
                begin
                    j_reg <= j_next;
                    i_reg <= i_dec;
                    if (i_reg == NW'(1))
                    begin
                        k_reg     <= '0;
                        state_reg <= O_RD;
                    end
                    else
                    begin
                        state_reg <= T_RD;
                    end
                end
                O_RD:
                begin
                    state_reg <= O_LOAD;
                end
                O_LOAD:
                begin
                    out_valid_reg <= 1'b1;
                    number_reg    <= NUM_W'(32'(k_reg) + 32'd1);
                    selected_reg  <= sel_q;
                    weight_reg    <= wgt_q;
                    profit_reg    <= prof_q;
                    last_reg      <= (k_inc == n_reg);
                    state_reg     <= O_WAIT;
                end
                O_WAIT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (last_reg)
                        begin
                            state_reg <= T_IDLE;
                        end
                        else
                        begin
                            k_reg     <= k_inc;
                            state_reg <= O_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign busy          = (state_reg != T_IDLE);
    assign out_valid     = out_valid_reg;
    assign item_number   = number_reg;
    assign selected      = selected_reg;
    assign out_weight    = weight_reg;
    assign out_profit    = profit_reg;
    assign total_profit  = total_reg;
    assign dropped_items = dropped_reg;
    assign last_result   = last_reg;

endmodule

>>> rtl/knapsack_01_solver_top.sv
// Top level of the 0/1 knapsack dynamic-programming solver.
// Depends on ks01_pkg, ks01_row_engine, ks01_trace_out and the assert header.
//
//  channel | direction | handshake             | beat
//  cfg     | in        | psel/penable/pready   | capacity register write or read
//  in      | in        | in_valid/in_ready     | item_profit, item_weight, is_last_item
//  out     | out       | out_valid/out_ready   | one result per held item
//
// Each item is folded in by one row-memory read-modify-write per capacity
// column, from MAX_CAPACITY down to 1; the row memory has a single write port.
// After the last item: total read, traceback over the held items from last to
// first, then one result per held item, each held until out_ready.
// After reset and after every set, a clearing pass over columns 0 to MAX_CAPACITY
// zeroes the row; no item is accepted meanwhile, configuration writes still are.
module knapsack_01_solver_top
    import ks01_pkg::*;
#(
    parameter int MAX_ITEMS    = 64,
    parameter int MAX_CAPACITY = 255
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [PROFIT_W-1:0] item_profit,
    input  logic [WEIGHT_W-1:0] item_weight,
    input  logic                is_last_item,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [NUM_W-1:0]    item_number,
    output logic                selected,
    output logic [WEIGHT_W-1:0] out_weight,
    output logic [PROFIT_W-1:0] out_profit,
    output logic [SUM_W-1:0]    total_profit,
    output logic                dropped_items,
    output logic                last_result
);

    localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int NW = IW + 1;
    localparam int CW = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY + 1) : 1;

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_UPD, S_TOT, S_TOTW, S_OUT} state_t;

    state_t           state_reg;
    logic [CFG_W-1:0] capacity_reg;
    logic [NW-1:0]    count_reg;
    logic             overflow_reg;
    logic [IW-1:0]    cur_idx_reg;
    logic             last_reg;

    logic             in_acc;
    logic             room;
    logic             cfg_wr;
    logic             start_update;
    logic             start_clear;
    logic             start_total;
    logic             trace_start;
    logic [CW-1:0]    cap_sat;
    logic             row_busy;
    logic             total_valid;
    logic [SUM_W-1:0] row_total;
    take_wr_t         take_wr;
    logic [CW-1:0]    take_col;
    logic             trace_busy;

    // Handshake decode
    always_comb
    begin
        in_ready     = (state_reg == S_IDLE);
        in_acc       = in_valid && in_ready;
        room         = (count_reg < NW'(MAX_ITEMS));
        start_update = in_acc && room;
        start_clear  = (state_reg == S_OUT) && !trace_busy;
        start_total  = (state_reg == S_TOT);
        trace_start  = (state_reg == S_TOTW) && total_valid;
        cap_sat      = (32'(capacity_reg) > MAX_CAPACITY) ? CW'(MAX_CAPACITY)
                                                          : CW'(capacity_reg);
        cfg_wr       = psel && penable && pwrite;
        pready       = 1'b1;
        prdata       = (paddr == ADDR_CAPACITY) ? 32'(capacity_reg) : '0;
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= '0;
        end
        else if (cfg_wr && (paddr[2] == ADDR_CAPACITY[2]))
        begin
            capacity_reg <= pwdata[CFG_W-1:0];
        end
    end

    // Set sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            cur_idx_reg  <= '0;
            last_reg     <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    if (!row_busy)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        last_reg <= is_last_item;
                        if (room)
                        begin
                            count_reg   <= count_reg + 1'b1;
                            cur_idx_reg <= count_reg[IW-1:0];
                            state_reg   <= S_UPD;
                        end
                        else
                        begin
                            overflow_reg <= 1'b1;
                            if (is_last_item)
                            begin
                                state_reg <= S_TOT;
                            end
                        end
                    end
                end
                S_UPD:
                begin
                    if (!row_busy)
                    begin
                        state_reg <= last_reg ? S_TOT : S_IDLE;
                    end
                end
                S_TOT:
                begin
                    state_reg <= S_TOTW;
                end
                S_TOTW:
                begin
                    if (total_valid)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!trace_busy)
                    begin
                        count_reg    <= '0;
                        overflow_reg <= 1'b0;
                        state_reg    <= S_CLEAR;
                    end
                end
                default:
                begin
                    state_reg <= S_CLEAR;
                end
            endcase
        end
    end

    ks01_row_engine #(
        .MAX_CAPACITY (MAX_CAPACITY)
    ) u_row (
        .clk          (clk),
        .rst_n        (rst_n),
        .start_update (start_update),
        .upd_profit   (item_profit),
        .upd_weight   (item_weight),
        .start_clear  (start_clear),
        .start_total  (start_total),
        .total_col    (cap_sat),
        .busy         (row_busy),
        .total_valid  (total_valid),
        .total        (row_total),
        .take_wr      (take_wr),
        .take_col     (take_col)
    );

    ks01_trace_out #(
        .MAX_ITEMS    (MAX_ITEMS),
        .MAX_CAPACITY (MAX_CAPACITY)
    ) u_trace (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_wr       (start_update),
        .item_idx      (count_reg[IW-1:0]),
        .wr_profit     (item_profit),
        .wr_weight     (item_weight),
        .take_wr       (take_wr),
        .take_idx      (cur_idx_reg),
        .take_col      (take_col),
        .start         (trace_start),
        .set_count     (count_reg),
        .cap           (cap_sat),
        .total_in      (row_total),
        .dropped_in    (overflow_reg),
        .busy          (trace_busy),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .item_number   (item_number),
        .selected      (selected),
        .out_weight    (out_weight),
        .out_profit    (out_profit),
        .total_profit  (total_profit),
        .dropped_items (dropped_items),
        .last_result   (last_result)
    );

`include "knapsack_01_solver_top_assert.svh"

    // An item arriving to a full store marks the set as overflowed
    `KS01_CHECK_NEXT(a_ovf_set, in_valid && in_ready && count_reg == NW'(MAX_ITEMS), overflow_reg)
    // Input is taken only while both engines are quiet
    `KS01_CHECK(a_ready_quiet, in_ready, !row_busy && !trace_busy)
    // Results appear only in the output phase
    `KS01_CHECK(a_out_phase, out_valid, state_reg == S_OUT)
    // Held item count never exceeds the store depth
    `KS01_CHECK(a_count_bound, 1'b1, count_reg <= NW'(MAX_ITEMS))

endmodule

>>> tb/tb_top.sv
// Self-checking bench for knapsack_01_solver_top: item sets go in, per-item picks come out.
// A local DP model predicts every result beat; depends on ks01_pkg and the solver RTL.
`timescale 1ns / 1ps

module tb_top;
    import ks01_pkg::*;

    localparam int MAX_ITEMS = 64;
    localparam int MAX_CAP   = 255;
    localparam int ROW_LEN   = MAX_CAP + 1;

    typedef struct packed {
        logic [PROFIT_W-1:0] profit;
        logic [WEIGHT_W-1:0] weight;
        logic                last;
    } item_t;

    typedef struct packed {
        logic [NUM_W-1:0]    num;
        logic                sel;
        logic [WEIGHT_W-1:0] weight;
        logic [PROFIT_W-1:0] profit;
        logic [SUM_W-1:0]    total;
        logic                dropped;
        logic                last;
    } pick_t;

    logic clk, rst_n;
    logic psel, penable, pwrite, pready;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;
    logic in_valid, in_ready;
    logic [PROFIT_W-1:0] item_profit;
    logic [WEIGHT_W-1:0] item_weight;
    logic is_last_item;
    logic out_valid, out_ready;
    logic [NUM_W-1:0] item_number;
    logic selected;
    logic [WEIGHT_W-1:0] out_weight;
    logic [PROFIT_W-1:0] out_profit;
    logic [SUM_W-1:0] total_profit;
    logic dropped_items, last_result;

    knapsack_01_solver_top i_dut (.*);

    // DP model state
    logic [SUM_W-1:0]    dp_row [ROW_LEN];
    logic                dp_take [MAX_ITEMS][ROW_LEN];
    logic [PROFIT_W-1:0] held_profit [MAX_ITEMS];
    logic [WEIGHT_W-1:0] held_weight [MAX_ITEMS];
    int                  held_cnt;
    logic                held_over;
    logic [CFG_W-1:0]    knap_cap;

    item_t item_q [$];
    pick_t pick_q [$];
    int    errors;
    int    picks_seen;
    int    sets_done;
    int    items_sent;

    // Fold one accepted item into the model; emits picks on the last item
    task automatic solve_item(item_t it);
        logic [SUM_W:0] cand;
        int j, i, n;
        logic sel [MAX_ITEMS];
        pick_t p;
        if (held_cnt < MAX_ITEMS) begin
            held_profit[held_cnt] = it.profit;
            held_weight[held_cnt] = it.weight;
            for (j = MAX_CAP; j >= 1; j--) begin
                dp_take[held_cnt][j] = 1'b0;
                if (it.weight <= j) begin
                    cand = dp_row[j - it.weight] + it.profit;
                    if (cand > SUM_MAX)
                        cand = SUM_MAX;
                    if (cand > dp_row[j]) begin
                        dp_row[j] = cand[SUM_W-1:0];
                        dp_take[held_cnt][j] = 1'b1;
                    end
                end
            end
            dp_take[held_cnt][0] = 1'b0;
            held_cnt++;
        end
        else
            held_over = 1'b1;
        if (!it.last)
            return;
        n = held_cnt;
        for (i = 0; i < MAX_ITEMS; i++)
            sel[i] = 1'b0;
        j = knap_cap;
        for (i = n; i != 0 && j != 0; i--) begin
            if (dp_take[i-1][j]) begin
                sel[i-1] = 1'b1;
                j = (j >= held_weight[i-1]) ? j - held_weight[i-1] : 0;
            end
        end
        for (i = 0; i < n; i++) begin
            p.num     = NUM_W'(i + 1);
            p.sel     = sel[i];
            p.weight  = held_weight[i];
            p.profit  = held_profit[i];
            p.total   = dp_row[knap_cap];
            p.dropped = held_over;
            p.last    = (i + 1 == n);
            pick_q.push_back(p);
        end
        for (j = 0; j < ROW_LEN; j++)
            dp_row[j] = '0;
        held_cnt  = 0;
        held_over = 1'b0;
        sets_done++;
    endtask

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("Regression FAIL");
        $finish;
    end

    // Item driver
    int in_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid     <= 1'b0;
            item_profit  <= '0;
            item_weight  <= '0;
            is_last_item <= 1'b0;
            in_gap       <= 0;
        end
        else begin
            if (in_valid && in_ready) begin
                solve_item({item_profit, item_weight, is_last_item});
                items_sent++;
            end
            if (!in_valid || in_ready) begin
                if (in_gap > 0 || item_q.size() == 0) begin
                    in_valid <= 1'b0;
                    if (in_gap > 0)
                        in_gap <= in_gap - 1;
                end
                else begin
                    item_t it;
                    it = item_q.pop_front();
                    in_valid     <= 1'b1;
                    item_profit  <= it.profit;
                    item_weight  <= it.weight;
                    is_last_item <= it.last;
                    in_gap       <= gap_len();
                end
            end
        end
    end

    // Result monitor with random back-pressure
    int out_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            out_gap   <= 0;
        end
        else begin
            if (out_valid && out_ready) begin
                pick_t e;
                picks_seen++;
                if (pick_q.size() == 0) begin
                    $error("unexpected result beat, item_number %0d", item_number);
                    errors++;
                end
                else begin
                    e = pick_q.pop_front();
                    if (item_number !== e.num) begin
                        $error("item_number exp %0d got %0d", e.num, item_number);
                        errors++;
                    end
                    if (selected !== e.sel) begin
                        $error("selected exp %0d got %0d", e.sel, selected);
                        errors++;
                    end
                    if (out_weight !== e.weight) begin
                        $error("out_weight exp %0d got %0d", e.weight, out_weight);
                        errors++;
                    end
                    if (out_profit !== e.profit) begin
                        $error("out_profit exp %0d got %0d", e.profit, out_profit);
                        errors++;
                    end
                    if (total_profit !== e.total) begin
                        $error("total_profit exp %0d got %0d", e.total, total_profit);
                        errors++;
                    end
                    if (dropped_items !== e.dropped) begin
                        $error("dropped_items exp %0d got %0d", e.dropped, dropped_items);
                        errors++;
                    end
                    if (last_result !== e.last) begin
                        $error("last_result exp %0d got %0d", e.last, last_result);
                        errors++;
                    end
                end
            end
            if (out_gap > 0) begin
                out_ready <= 1'b0;
                out_gap   <= out_gap - 1;
            end
            else begin
                out_ready <= 1'b1;
                out_gap   <= gap_len();
            end
        end
    end

    // APB write of the capacity register, model updated on the access edge
    task automatic write_cap(logic [CFG_W-1:0] cap);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_CAPACITY;
        pwdata  <= {24'd0, cap};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        knap_cap = cap;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Wait for all queued items to go in and all picks to come out
    task automatic drain();
        while (item_q.size() != 0 || in_valid || pick_q.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    function automatic item_t rand_item(int wmax, logic last);
        item_t it;
        int r;
        r = $urandom_range(0, 9);
        it.profit = (r == 0) ? 16'hFFFF : (r == 1) ? 16'd0 : 16'($urandom_range(0, 65535));
        r = $urandom_range(0, 9);
        it.weight = (r == 0) ? 8'd0 : (r == 1) ? 8'hFF : 8'($urandom_range(0, wmax));
        it.last   = last;
        return it;
    endfunction

    // Push one set of n random items, last one flagged
    task automatic add_set(int n, int wmax);
        for (int i = 0; i < n; i++)
            item_q.push_back(rand_item(wmax, i == n - 1));
    endtask

    initial
    begin
        int n;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        errors = 0; picks_seen = 0; sets_done = 0; items_sent = 0;
        held_cnt = 0; held_over = 1'b0; knap_cap = '0;
        for (int j = 0; j < ROW_LEN; j++)
            dp_row[j] = '0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Capacity zero: nothing can be picked
        item_q.push_back('{16'd500, 8'd0, 1'b0});
        item_q.push_back('{16'hFFFF, 8'd1, 1'b1});
        drain();

        // Full capacity, extreme fields, zero-weight and zero-profit items
        write_cap(8'hFF);
        item_q.push_back('{16'hFFFF, 8'hFF, 1'b0});
        item_q.push_back('{16'd0, 8'd0, 1'b0});
        item_q.push_back('{16'd7, 8'd0, 1'b0});
        item_q.push_back('{16'd100, 8'd128, 1'b0});
        item_q.push_back('{16'd100, 8'd127, 1'b0});
        item_q.push_back('{16'hAAAA, 8'h55, 1'b1});
        drain();

        // Small capacity, ties must not set the take bit
        write_cap(8'd10);
        item_q.push_back('{16'd10, 8'd5, 1'b0});
        item_q.push_back('{16'd10, 8'd5, 1'b0});
        item_q.push_back('{16'd10, 8'd5, 1'b0});
        item_q.push_back('{16'd20, 8'd10, 1'b0});
        item_q.push_back('{16'h5555, 8'd11, 1'b1});
        drain();

        // Single-item set
        write_cap(8'd1);
        item_q.push_back('{16'd1, 8'd1, 1'b1});
        drain();

        // Overflowing set: 66 items, extras dropped
        write_cap(8'd200);
        add_set(66, 40);
        drain();

        // Random sets over several capacities
        while (items_sent < 360) begin
            write_cap((sets_done % 5 == 0) ? 8'($urandom_range(0, 255)) :
                      (sets_done % 5 == 1) ? 8'hFF : 8'($urandom_range(1, 60)));
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 64) : $urandom_range(1, 12);
            add_set(n, ($urandom_range(0, 1) != 0) ? 30 : 255);
            drain();
        end

        $display("Covered %0d item sets, %0d items in, %0d result beats checked",
                 sets_done, items_sent, picks_seen);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> knapsack_01_solver_top.f
+incdir+rtl
rtl/ks01_pkg.sv
rtl/ks01_row_engine.sv
rtl/ks01_trace_out.sv
rtl/knapsack_01_solver_top.sv
tb/tb_top.sv
